/* rtl/core/vad_pkg.sv */
// ============================================================================
// VAG ADPCM decoder package
// Shared payload types, state machine encoding, constants and the predictor
// coefficient tables for the VAG ADPCM decoder.
// ============================================================================
package vad_pkg;

    // Defaults for the top level parameters.
    localparam int CHANNELS_DEF  = 2;
    localparam int FRAC_BITS_DEF = 6;

    // History integer bits above the fraction (history width = this + FRAC_BITS).
    localparam int HIST_INT_BITS = 18;

    // Predictor coefficients are signed values in 1/64 units.
    localparam int COEF_W     = 8;
    localparam int COEF_SHIFT = 6;

    // The nibble lands in bits 15..12 of a 16-bit word before the shift.
    localparam int NIB_POS = 12;

    // Positions within the 16-byte line and the flag code that stops it.
    localparam logic [3:0] HEADER_POS = 4'd0;
    localparam logic [3:0] FLAGS_POS  = 4'd1;
    localparam logic [7:0] STOP_FLAG  = 8'h07;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chan;
        logic       clear_history;
    } t_in;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               out_chan;
        logic               last_of_pair;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_EMIT,
        ST_WB
    } t_state;

    // First tap: weight of the most recent sample. Unknown filters predict nothing.
    function automatic logic signed [COEF_W-1:0] coef_one(input logic [3:0] filt);
        logic signed [COEF_W-1:0] c;
        case (filt)
            4'd1:    c = 8'sd60;
            4'd2:    c = 8'sd115;
            4'd3:    c = 8'sd98;
            4'd4:    c = 8'sd122;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    // Second tap: weight of the sample before that.
    function automatic logic signed [COEF_W-1:0] coef_two(input logic [3:0] filt);
        logic signed [COEF_W-1:0] c;
        case (filt)
            4'd2:    c = -8'sd52;
            4'd3:    c = -8'sd55;
            4'd4:    c = -8'sd60;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/vag_adpcm_decoder.sv */
// ============================================================================
// VAG ADPCM decoder
// Decodes interleaved-channel VAG ADPCM bytes into saturated 16-bit PCM.
// ============================================================================
// The decoder takes one ADPCM byte per input transfer, tagged with a channel,
// and handles one byte at a time. Each channel walks its own 16-byte line:
// the header byte sets shift and filter, the flags byte may stop the rest of
// the line (flag value 7), and each of the fourteen data bytes produces two
// output transfers, low nibble first, the second marked by last_of_pair. A
// header or flags byte, or a data byte of a stopped line, goes from the load
// state straight to the write-back state. For a data byte, one shared
// multiplier performs the four predictor multiplies, the two of each sample
// in successive states; each sample then passes a summing state and an
// output state that waits while the output side stalls. A byte whose channel
// is at or above CHANNELS is dropped in the read state, with no output. The
// per-channel state (two history samples, line position, shift, filter and
// stop flag) lives in one small memory with a registered read; it is read
// after the input transfer, worked on in local registers and written back
// before the next byte is taken, so no two accesses to an entry overlap.
// Entries read as zero until first written, and clear_history zeroes the
// channel state before the byte is used, starting a new line.
module vag_adpcm_decoder #(
    parameter int CHANNELS  = vad_pkg::CHANNELS_DEF,
    parameter int FRAC_BITS = vad_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vad_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output vad_pkg::t_out o_data
);
    import vad_pkg::*;

    localparam int HIST_BITS = HIST_INT_BITS + FRAC_BITS;
    localparam int PROD_W    = HIST_BITS + COEF_W;
    localparam int ACC_W     = HIST_BITS + 3;
    localparam int RND_W     = HIST_BITS + 1;
    localparam int AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic signed [ACC_W-1:0] HMAX =
        ACC_W'((64'sd1 <<< (HIST_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] HMIN = -HMAX - ACC_W'(1);
    localparam logic signed [RND_W-1:0] HALF = RND_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [RND_W-1:0] PCM_MAX = RND_W'(32767);
    localparam logic signed [RND_W-1:0] PCM_MIN = -RND_W'(32768);

    typedef struct packed {
        logic signed [HIST_BITS-1:0] h1;
        logic signed [HIST_BITS-1:0] h2;
        logic [3:0]                  pos;
        logic [3:0]                  shift;
        logic [3:0]                  filt;
        logic                        stop;
    } t_entry;

    // Channel state memory and its per-entry written marks.
    t_entry                mem [CHANNELS];
    t_entry                r_rd;
    logic [CHANNELS-1:0]   r_vld;

    t_state                r_state, n_state;
    t_in                   r_in;
    logic signed [HIST_BITS-1:0] r_h1, r_h2;
    logic [3:0]            r_pos, r_shift, r_filt;
    logic                  r_stop;
    logic                  r_nib_hi;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    t_out                  r_out;
    logic                  r_out_valid;

    logic [AW-1:0]         w_addr;
    logic                  w_chan_ok;
    t_entry                w_cur;
    logic                  w_data_go;
    logic                  w_slot_free;
    logic                  w_emit;
    logic                  w_wr;
    logic                  w_accept;

    logic [3:0]                  w_nib;
    logic signed [15:0]          w_v16;
    logic signed [15:0]          w_vsh;
    logic signed [ACC_W-1:0]     w_vscaled;
    logic signed [HIST_BITS-1:0] w_mul_a;
    logic signed [COEF_W-1:0]    w_mul_c;
    logic signed [ACC_W-1:0]     w_prod_q;
    logic signed [ACC_W-1:0]     w_sum;
    logic signed [HIST_BITS-1:0] w_sum_sat;
    logic signed [RND_W-1:0]     w_rnd;
    logic signed [15:0]          w_pcm;

    assign w_addr      = AW'(r_in.chan);
    assign w_chan_ok   = (32'(r_in.chan) < CHANNELS);
    assign w_slot_free = !r_out_valid || i_ready;
    assign w_accept    = i_valid && o_ready;

    // Entry as seen after reset marks and the clear request are applied.
    assign w_cur     = (r_vld[w_addr] && !r_in.clear_history) ? r_rd : '0;
    assign w_data_go = (w_cur.pos != HEADER_POS) && (w_cur.pos != FLAGS_POS) && !w_cur.stop;

    // Nibble value: placed in the top bits, arithmetic shift, scaled to Q format.
    assign w_nib     = r_nib_hi ? r_in.data_byte[7:4] : r_in.data_byte[3:0];
    assign w_v16     = {w_nib, {NIB_POS{1'b0}}};
    assign w_vsh     = w_v16 >>> r_shift;
    assign w_vscaled = ACC_W'(w_vsh) <<< FRAC_BITS;

    // The shared multiplier takes the first tap, then the second.
    assign w_mul_a  = (r_state == ST_MUL_A) ? r_h1 : r_h2;
    assign w_mul_c  = (r_state == ST_MUL_A) ? coef_one(r_filt) : coef_two(r_filt);
    assign w_prod_q = ACC_W'(r_prod >>> COEF_SHIFT);

    always_comb begin
        w_sum = r_acc + w_prod_q;
        if (w_sum > HMAX) begin
            w_sum_sat = HIST_BITS'(HMAX);
        end else if (w_sum < HMIN) begin
            w_sum_sat = HIST_BITS'(HMIN);
        end else begin
            w_sum_sat = HIST_BITS'(w_sum);
        end
    end

    // Round half up to integer units, then saturate to 16 bits.
    always_comb begin
        w_rnd = (RND_W'(r_h1) + HALF) >>> FRAC_BITS;
        if (w_rnd > PCM_MAX) begin
            w_pcm = 16'sh7fff;
        end else if (w_rnd < PCM_MIN) begin
            w_pcm = -16'sh8000;
        end else begin
            w_pcm = 16'(w_rnd);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_READ;
            ST_READ:  n_state = w_chan_ok ? ST_LOAD : ST_IDLE;
            ST_LOAD:  n_state = w_data_go ? ST_MUL_A : ST_WB;
            ST_MUL_A: n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_SUM;
            ST_SUM:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_state = r_nib_hi ? ST_WB : ST_MUL_A;
                end
            end
            ST_WB:    n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb begin
        o_ready = 1'b0;
        w_emit  = 1'b0;
        w_wr    = 1'b0;
        case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_EMIT: w_emit  = w_slot_free;
            ST_WB:   w_wr    = 1'b1;
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wr) begin
                r_vld[w_addr] <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // State memory: registered read, write-back at the end of a byte.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rd <= mem[w_addr];
        end
        if (w_wr) begin
            mem[w_addr] <= '{h1: r_h1, h2: r_h2, pos: r_pos, shift: r_shift,
                             filt: r_filt, stop: r_stop};
        end
    end

    // Working registers and datapath.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_data;
        end
        case (r_state)
            ST_LOAD: begin
                r_h1     <= w_cur.h1;
                r_h2     <= w_cur.h2;
                r_pos    <= w_cur.pos + 4'd1;
                r_nib_hi <= 1'b0;
                if (w_cur.pos == HEADER_POS) begin
                    r_shift <= r_in.data_byte[3:0];
                    r_filt  <= r_in.data_byte[7:4];
                end else begin
                    r_shift <= w_cur.shift;
                    r_filt  <= w_cur.filt;
                end
                if (w_cur.pos == FLAGS_POS) begin
                    r_stop <= (r_in.data_byte == STOP_FLAG);
                end else begin
                    r_stop <= w_cur.stop;
                end
            end
            ST_MUL_A: begin
                r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_c);
                r_acc  <= w_vscaled;
            end
            ST_MUL_B: begin
                r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_c);
                r_acc  <= r_acc + w_prod_q;
            end
            ST_SUM: begin
                r_h2 <= r_h1;
                r_h1 <= w_sum_sat;
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    r_nib_hi <= 1'b1;
                end
            end
            default: begin
                r_nib_hi <= r_nib_hi;
            end
        endcase
        if (w_emit) begin
            r_out.pcm_sample   <= w_pcm;
            r_out.out_chan     <= r_in.chan;
            r_out.last_of_pair <= r_nib_hi;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // A memory read always follows an input transfer.
    a_read_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> $past(i_valid && o_ready))
        else $error("state read without an input transfer");

    // Multiply sequence starts only from a loaded entry or after the first sample.
    a_mul_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL_A) |-> ($past(r_state) == ST_LOAD || $past(r_state) == ST_EMIT))
        else $error("multiply sequence entered from a wrong state");

    // A new output appears only from the output state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(o_valid) |-> $past(r_state == ST_EMIT))
        else $error("output raised outside the output state");

    // Written marks are never withdrawn outside reset.
    a_vld_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_vld & $past(r_vld)) == $past(r_vld)))
        else $error("written mark of a channel entry was lost");

endmodule
